[design/cdsc_pkg.sv]
// Shared types and constants for the clock display and set controller.
`default_nettype none

package cdsc_pkg;

    // Request kind carried on the input tuser
    typedef enum logic [1:0] {
        REQ_TICK = 2'd0,
        REQ_KEY  = 2'd1,
        REQ_LOAD = 2'd2
    } t_req;

    typedef enum logic [2:0] {
        MODE_NORMAL = 3'd0,
        MODE_HOUR   = 3'd1,
        MODE_MINUTE = 3'd2,
        MODE_SAVE   = 3'd3,
        MODE_TEMP   = 3'd4,
        MODE_HUMID  = 3'd5
    } t_mode;

    typedef enum logic [1:0] {
        CFG_BLINK  = 2'd0,
        CFG_ADJUST = 2'd1,
        CFG_TOUCH  = 2'd2
    } t_cfg_idx;

    localparam logic [3:0] GLYPH_BLANK = 4'd10;
    localparam logic [3:0] GLYPH_P     = 4'd11;
    localparam logic [3:0] GLYPH_NONE  = 4'd12;

    // Key levels (bits 0..3, 1 = released)
    localparam logic [3:0] KEYS_IDLE = 4'hF;
    localparam logic [3:0] KEY_MODE  = 4'hE;
    localparam logic [3:0] KEY_DOWN  = 4'hD;
    localparam logic [3:0] KEY_UP    = 4'hB;
    localparam logic [3:0] KEY_BEEP  = 4'h7;

    localparam logic [10:0] MODE_HOLD_LIMIT = 11'd2001;
    localparam logic [3:0]  MODE_STEP_LAST  = 4'd9;
    localparam logic [4:0]  HOUR_MAX        = 5'd23;
    localparam logic [5:0]  MINUTE_MAX      = 6'd59;
    localparam logic [6:0]  READING_MAX     = 7'd99;
    localparam logic [2:0]  POS_COLON       = 3'd4;

    localparam logic [14:0] RST_BLINK_HALF  = 15'd400;
    localparam logic [7:0]  RST_ADJUST      = 8'd10;
    localparam logic [7:0]  RST_TOUCH       = 8'd30;

    typedef struct packed {
        logic [14:0] blink_half_period;
        logic [7:0]  adjust_repeat_ticks;
        logic [7:0]  touch_repeat_ticks;
    } t_cfg;

    typedef struct packed {
        logic [1:0] req_type;
        logic [4:0] keys;
        logic [3:0] digit_first;
        logic [3:0] digit_second;
        logic [3:0] digit_third;
        logic [3:0] digit_fourth;
        logic [6:0] temperature;
        logic [6:0] humidity;
        logic [4:0] load_hour;
        logic [5:0] load_minute;
        logic [5:0] load_second;
    } t_item;

    typedef struct packed {
        logic [2:0] position;
        logic [3:0] glyph;
        logic       colon_on;
        logic [2:0] mode;
        logic [4:0] hour;
        logic [5:0] minute;
        logic [5:0] second;
        logic       rtc_write;
        logic       beep;
    } t_result;

endpackage

`default_nettype wire

[design/cdsc_cfg_regs.sv]
// Configuration register file: blink period and key repeat counts.
`default_nettype none

module cdsc_cfg_regs
    import cdsc_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_wr,
    input  wire logic [1:0]  i_index,
    input  wire logic [14:0] i_data,
    output t_cfg             o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.blink_half_period   <= RST_BLINK_HALF;
            r_cfg.adjust_repeat_ticks <= RST_ADJUST;
            r_cfg.touch_repeat_ticks  <= RST_TOUCH;
        end else if (i_wr) begin
            case (t_cfg_idx'(i_index))
                CFG_BLINK:  r_cfg.blink_half_period   <= i_data;
                CFG_ADJUST: r_cfg.adjust_repeat_ticks <= i_data[7:0];
                CFG_TOUCH:  r_cfg.touch_repeat_ticks  <= i_data[7:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

[design/cdsc_core.sv]
// Panel state and the per-transaction update / glyph selection logic.
`default_nettype none

module cdsc_core
    import cdsc_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_fire,
    input  wire t_item i_item,
    input  wire t_cfg  i_cfg,
    output t_result    o_res
);

    function automatic logic [3:0] div10(input logic [6:0] v);
        logic [14:0] p;
        p = 15'(v) * 15'd205;   // exact for every 7-bit v (0..127)
        return p[14:11];
    endfunction

    function automatic logic [3:0] mod10(input logic [6:0] v, input logic [3:0] q);
        logic [6:0] t;
        t = 7'(v - 7'(q) * 7'd10);
        return t[3:0];
    endfunction

    function automatic logic [3:0] digit_glyph(input logic [3:0] d);
        return (d > 4'd9) ? GLYPH_BLANK : d;
    endfunction

    t_mode       r_mode,      n_mode;
    logic [2:0]  r_scan,      n_scan;
    logic [15:0] r_blink,     n_blink;
    logic [4:0]  r_hour,      n_hour;
    logic [5:0]  r_minute,    n_minute;
    logic [5:0]  r_second,    n_second;
    logic [10:0] r_mode_hold, n_mode_hold;
    logic [3:0]  r_mode_mod,  n_mode_mod;   // mode_hold mod 10
    logic [7:0]  r_down,      n_down;
    logic [7:0]  r_up,        n_up;
    logic [7:0]  r_touch,     n_touch;

    logic [15:0] w_blink_inc;
    logic        w_on;
    logic [3:0]  w_h1, w_h0, w_m1, w_m0, w_v1, w_v0;
    logic [6:0]  w_reading;
    logic [3:0]  w_g [4];
    logic [3:0]  w_keylv;
    logic        w_touch;
    t_result     w_res;

    always_comb begin
        n_mode      = r_mode;
        n_scan      = r_scan;
        n_blink     = r_blink;
        n_hour      = r_hour;
        n_minute    = r_minute;
        n_second    = r_second;
        n_mode_hold = r_mode_hold;
        n_mode_mod  = r_mode_mod;
        n_down      = r_down;
        n_up        = r_up;
        n_touch     = r_touch;

        w_res          = '0;
        w_res.glyph    = GLYPH_NONE;

        w_blink_inc = r_blink + 16'd1;
        w_on        = 1'b0;
        w_h1 = div10({2'b00, r_hour});
        w_h0 = mod10({2'b00, r_hour}, w_h1);
        w_m1 = div10({1'b0, r_minute});
        w_m0 = mod10({1'b0, r_minute}, w_m1);
        w_reading = (r_mode == MODE_TEMP) ? i_item.temperature : i_item.humidity;
        if (w_reading > READING_MAX) begin
            w_reading = READING_MAX;
        end
        w_v1 = div10(w_reading);
        w_v0 = mod10(w_reading, w_v1);
        for (int k = 0; k < 4; k++) begin
            w_g[k] = GLYPH_NONE;
        end
        w_keylv = i_item.keys[3:0];
        w_touch = i_item.keys[4];

        case (t_req'(i_item.req_type))
            REQ_TICK: begin
                n_blink = (w_blink_inc > {i_cfg.blink_half_period, 1'b0}) ? '0 : w_blink_inc;
                w_on    = n_blink < {1'b0, i_cfg.blink_half_period};
                w_res.position = r_scan;
                case (r_mode)
                    MODE_NORMAL: begin
                        w_g[0] = digit_glyph(i_item.digit_first);
                        w_g[1] = digit_glyph(i_item.digit_second);
                        w_g[2] = digit_glyph(i_item.digit_third);
                        w_g[3] = digit_glyph(i_item.digit_fourth);
                        w_res.colon_on = (r_scan == POS_COLON) && w_on;
                    end
                    MODE_HOUR: begin
                        w_g[0] = w_on ? w_h1 : GLYPH_BLANK;
                        w_g[1] = w_on ? w_h0 : GLYPH_BLANK;
                        w_g[2] = w_m1;
                        w_g[3] = w_m0;
                        w_res.colon_on = (r_scan == POS_COLON);
                    end
                    MODE_MINUTE: begin
                        w_g[0] = w_h1;
                        w_g[1] = w_h0;
                        w_g[2] = w_on ? w_m1 : GLYPH_BLANK;
                        w_g[3] = w_on ? w_m0 : GLYPH_BLANK;
                        w_res.colon_on = (r_scan == POS_COLON);
                    end
                    MODE_SAVE: begin
                        w_res.rtc_write = 1'b1;
                        n_mode = MODE_NORMAL;
                    end
                    MODE_TEMP, MODE_HUMID: begin
                        w_g[0] = GLYPH_P;
                        w_g[1] = (r_mode == MODE_TEMP) ? 4'd1 : 4'd2;
                        w_g[2] = w_v1;
                        w_g[3] = w_v0;
                        w_res.colon_on = (r_scan == POS_COLON);
                    end
                    default: ;
                endcase
                if (r_mode == MODE_NORMAL || r_mode == MODE_HOUR || r_mode == MODE_MINUTE
                    || r_mode == MODE_TEMP || r_mode == MODE_HUMID) begin
                    w_res.glyph = (r_scan == POS_COLON) ? GLYPH_BLANK : w_g[r_scan[1:0]];
                end
                n_scan = (r_scan >= POS_COLON) ? 3'd0 : 3'(r_scan + 3'd1);
            end
            REQ_KEY: begin
                if (w_keylv == KEYS_IDLE && !w_touch) begin
                    n_mode_hold = '0;
                    n_mode_mod  = '0;
                    n_down      = '0;
                    n_up        = '0;
                    n_touch     = '0;
                end else if (w_keylv == KEY_MODE && !w_touch) begin
                    w_res.beep = 1'b1;
                    if (r_mode_hold < MODE_HOLD_LIMIT) begin
                        n_mode_hold = 11'(r_mode_hold + 11'd1);
                        n_mode_mod  = (r_mode_mod == MODE_STEP_LAST) ? 4'd0
                                                                     : 4'(r_mode_mod + 4'd1);
                    end
                    if (n_mode_mod == 4'd0) begin
                        n_mode = (r_mode > MODE_MINUTE) ? MODE_NORMAL
                                                        : t_mode'(3'(r_mode) + 3'd1);
                    end
                end else if (w_keylv == KEY_DOWN && !w_touch) begin
                    w_res.beep = 1'b1;
                    if (r_down < i_cfg.adjust_repeat_ticks) begin
                        n_down = 8'(r_down + 8'd1);
                    end else begin
                        n_down = '0;
                        if (r_mode == MODE_HOUR) begin
                            n_hour = (r_hour > 5'd0) ? 5'(r_hour - 5'd1) : HOUR_MAX;
                        end else if (r_mode == MODE_MINUTE) begin
                            n_minute = (r_minute > 6'd0) ? 6'(r_minute - 6'd1) : MINUTE_MAX;
                        end
                    end
                end else if (w_keylv == KEY_UP && !w_touch) begin
                    w_res.beep = 1'b1;
                    if (r_up < i_cfg.adjust_repeat_ticks) begin
                        n_up = 8'(r_up + 8'd1);
                    end else begin
                        n_up = '0;
                        if (r_mode == MODE_HOUR) begin
                            n_hour = (r_hour < HOUR_MAX) ? 5'(r_hour + 5'd1) : 5'd0;
                        end else if (r_mode == MODE_MINUTE) begin
                            n_minute = (r_minute < MINUTE_MAX) ? 6'(r_minute + 6'd1) : 6'd0;
                        end
                    end
                end else if (w_keylv == KEY_BEEP && !w_touch) begin
                    w_res.beep = 1'b1;
                end else if (w_keylv == KEYS_IDLE && w_touch) begin
                    if (r_touch < i_cfg.touch_repeat_ticks) begin
                        n_touch = 8'(r_touch + 8'd1);
                    end else begin
                        n_touch = '0;
                        case (r_mode)
                            MODE_NORMAL: n_mode = MODE_TEMP;
                            MODE_TEMP:   n_mode = MODE_HUMID;
                            MODE_HOUR,
                            MODE_MINUTE: n_mode = MODE_SAVE;
                            MODE_HUMID:  n_mode = MODE_NORMAL;
                            default: ;
                        endcase
                    end
                end
            end
            REQ_LOAD: begin
                n_hour   = (i_item.load_hour > HOUR_MAX) ? HOUR_MAX : i_item.load_hour;
                n_minute = (i_item.load_minute > MINUTE_MAX) ? MINUTE_MAX : i_item.load_minute;
                n_second = (i_item.load_second > MINUTE_MAX) ? MINUTE_MAX : i_item.load_second;
            end
            default: ;
        endcase

        w_res.mode   = 3'(n_mode);
        w_res.hour   = n_hour;
        w_res.minute = n_minute;
        w_res.second = n_second;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_NORMAL;
            r_scan      <= '0;
            r_blink     <= '0;
            r_hour      <= '0;
            r_minute    <= '0;
            r_second    <= '0;
            r_mode_hold <= '0;
            r_mode_mod  <= '0;
            r_down      <= '0;
            r_up        <= '0;
            r_touch     <= '0;
        end else if (i_fire) begin
            r_mode      <= n_mode;
            r_scan      <= n_scan;
            r_blink     <= n_blink;
            r_hour      <= n_hour;
            r_minute    <= n_minute;
            r_second    <= n_second;
            r_mode_hold <= n_mode_hold;
            r_mode_mod  <= n_mode_mod;
            r_down      <= n_down;
            r_up        <= n_up;
            r_touch     <= n_touch;
        end
    end

    assign o_res = w_res;

endmodule

`default_nettype wire

[design/clock_display_and_set_controller_top.sv]
// Top level: stream ports, input and result registers, configuration port.
//
// Four-digit clock panel controller. Each input transaction is a refresh
// tick, a key sample or a time load (kind on s_axis_tuser); each gives
// exactly one result transaction on the master side carrying the scanned
// position and glyph, colon, mode, stored time and the rtc_write / beep flags.
// An accepted transaction is registered in the input register, processed
// into the result register and then presented as valid on m_axis_*.
// Throughput: one transaction per cycle unless the receiver stalls; the
// panel state updates in one pass of logic between the two registers.
// When the receiver stalls, the result is held in the output register and
// one more transaction waits in the input register; s_axis_tready drops
// only when both are full.
// Configuration writes (i_cfg_*) are always taken (o_cfg_ready is high) and
// should be issued only while no transaction is in flight. Index 0 blink
// half period, 1 adjust repeat, 2 touch repeat; other indexes are ignored.
// Reset (i_rst_n low, synchronous) empties both registers, restores the
// register defaults and clears mode, time, scan and hold counters.
`default_nettype none

module clock_display_and_set_controller_top
    import cdsc_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // configuration write channel
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [14:0] i_cfg_data,
    // input stream
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // [4:0] keys, [8:5] digit_first, [12:9] digit_second, [16:13] digit_third,
    // [20:17] digit_fourth, [27:21] temperature, [34:28] humidity,
    // [39:35] load_hour, [45:40] load_minute, [51:46] load_second, [55:52] zero
    input  wire logic [55:0] s_axis_tdata,
    // [1:0] req_type
    input  wire logic [1:0]  s_axis_tuser,
    // result stream
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [2:0] position, [6:3] glyph, [7] colon_on, [10:8] mode, [15:11] hour,
    // [21:16] minute, [27:22] second, [28] rtc_write, [29] beep, [31:30] zero
    output logic [31:0]      m_axis_tdata
);

    t_cfg    w_cfg;
    t_item   w_item;
    t_result w_res;
    logic    w_adv;
    logic    w_fire;

    logic    r_in_valid;
    t_item   r_in_item;
    logic    r_out_valid;
    t_result r_out;

    assign o_cfg_ready = 1'b1;

    cdsc_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (i_cfg_valid),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (w_cfg)
    );

    always_comb begin
        w_item.req_type     = s_axis_tuser;
        w_item.keys         = s_axis_tdata[4:0];
        w_item.digit_first  = s_axis_tdata[8:5];
        w_item.digit_second = s_axis_tdata[12:9];
        w_item.digit_third  = s_axis_tdata[16:13];
        w_item.digit_fourth = s_axis_tdata[20:17];
        w_item.temperature  = s_axis_tdata[27:21];
        w_item.humidity     = s_axis_tdata[34:28];
        w_item.load_hour    = s_axis_tdata[39:35];
        w_item.load_minute  = s_axis_tdata[45:40];
        w_item.load_second  = s_axis_tdata[51:46];
    end

    assign w_adv         = !r_out_valid || m_axis_tready;
    assign w_fire        = r_in_valid && w_adv;
    assign s_axis_tready = !r_in_valid || w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_item <= w_item;
        end
    end

    cdsc_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (w_fire),
        .i_item  (r_in_item),
        .i_cfg   (w_cfg),
        .o_res   (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out <= w_res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {2'b00, r_out.beep, r_out.rtc_write, r_out.second, r_out.minute,
                            r_out.hour, r_out.mode, r_out.colon_on, r_out.glyph,
                            r_out.position};

    a_colon_at_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.colon_on |-> r_out.position == POS_COLON)
        else $error("colon lit away from the colon position");

    a_save_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.rtc_write |-> r_out.glyph == GLYPH_NONE
            && r_out.mode == 3'(MODE_NORMAL) && !r_out.colon_on)
        else $error("save result does not return to normal with no drive");

    a_time_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> r_out.hour <= HOUR_MAX && r_out.minute <= MINUTE_MAX
            && r_out.second <= MINUTE_MAX)
        else $error("stored time out of range");

    a_beep_key_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.beep |-> r_out.glyph == GLYPH_NONE && r_out.position == 3'd0)
        else $error("beep on a refresh tick result");

    a_fire_fills_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire |=> r_out_valid)
        else $error("processed transaction lost before the result register");

endmodule

`default_nettype wire
